[design/tas_pkg.sv]
// Shared types and constants for the trace amplitude statistics block.
package tas_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int LEN_W           = 16;
  localparam logic [LEN_W-1:0] LEN_RESET = 16'd1000;
  localparam int Q_W             = 64;

  typedef enum logic [1:0] {
    SEL_MEAN = 2'd0,
    SEL_ABS  = 2'd1,
    SEL_RMS  = 2'd2
  } sel_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    sel_t sel;
    logic root_load;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic trace_end;
    logic div_last;
    logic root_last;
    logic out_full;
  } stat_t;

endpackage

[design/tas_if.sv]
// Item channels for samples and per-trace results.
interface tas_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          new_set;
  modport source (output valid, output sample, output new_set, input ready);
  modport sink   (input valid, input sample, input new_set, output ready);
endinterface

interface tas_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] trace_mean;
  logic        [30:0] trace_abs_mean;
  logic        [30:0] trace_rms;
  logic signed [31:0] min_of_means;
  logic signed [31:0] max_of_means;
  logic        [30:0] min_of_abs_means;
  logic        [30:0] max_of_abs_means;
  logic        [30:0] min_of_rms;
  logic        [30:0] max_of_rms;
  modport source (output valid, output trace_mean, output trace_abs_mean, output trace_rms,
                  output min_of_means, output max_of_means, output min_of_abs_means,
                  output max_of_abs_means, output min_of_rms, output max_of_rms,
                  input ready);
  modport sink   (input valid, input trace_mean, input trace_abs_mean, input trace_rms,
                  input min_of_means, input max_of_means, input min_of_abs_means,
                  input max_of_abs_means, input min_of_rms, input max_of_rms,
                  output ready);
endinterface

[design/tas_ctrl.sv]
// Controller state machine: sample accept, divide and root sequencing, result load.
module tas_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tas_pkg::stat_t stat,
  output tas_pkg::cmd_t  cmd
);
  import tas_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_DIV_START  = 6'b000010,
    S_DIV        = 6'b000100,
    S_ROOT_START = 6'b001000,
    S_ROOT       = 6'b010000,
    S_OUT        = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  sel_t   sel_r, sel_nxt;

  // Decode state into datapath commands
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.trace_end) begin
            sel_nxt   = SEL_MEAN;
            state_nxt = S_DIV_START;
          end
        end
      end
      S_DIV_START: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          unique case (sel_r)
            SEL_MEAN: begin
              sel_nxt   = SEL_ABS;
              state_nxt = S_DIV_START;
            end
            SEL_ABS: begin
              sel_nxt   = SEL_RMS;
              state_nxt = S_DIV_START;
            end
            default: state_nxt = S_ROOT_START;
          endcase
        end
      end
      S_ROOT_START: begin
        cmd.root_load = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_MEAN;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

[design/tas_dp.sv]
// Datapath: accumulators, serial divider, serial square root, ranges and result register.
module tas_dp #(
  parameter int SAMPLE_BITS = tas_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = tas_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tas_pkg::LEN_W-1:0]     cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          new_set,
  input  logic                          out_ready,
  input  tas_pkg::cmd_t                 cmd,
  output tas_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic signed [31:0]            trace_mean,
  output logic        [30:0]            trace_abs_mean,
  output logic        [30:0]            trace_rms,
  output logic signed [31:0]            min_of_means,
  output logic signed [31:0]            max_of_means,
  output logic        [30:0]            min_of_abs_means,
  output logic        [30:0]            max_of_abs_means,
  output logic        [30:0]            min_of_rms,
  output logic        [30:0]            max_of_rms
);
  import tas_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + LEN_W;
  localparam int SQ_W  = (2 * SAMPLE_BITS + 15 > 64) ? 64 : 2 * SAMPLE_BITS + 15;
  localparam int DVD_W = SQ_W + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);
  localparam logic [Q_W-1:0] SAT_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 64'h0000_0000_8000_0000;
  localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Configuration and accumulators
  logic [LEN_W-1:0]             len_r;
  logic signed [SUM_W-1:0]      sum_r, sum_nxt, snap_sum_r;
  logic [SUM_W-1:0]             mag_sum_r, mag_sum_nxt, snap_mag_r;
  logic [SQ_W-1:0]              sq_sum_r, sq_sum_nxt, snap_sq_r;
  logic [LEN_W-1:0]             seen_r, n_r;
  logic [LEN_W:0]               count;
  logic [LEN_W-1:0]             limit;
  logic [SAMPLE_BITS-1:0]       mag;
  logic [2*SAMPLE_BITS-1:0]     mag_sq;

  always_comb begin
    mag         = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    mag_sq      = mag * mag;
    sum_nxt     = (new_set ? '0 : sum_r) + SUM_W'(sample);
    mag_sum_nxt = (new_set ? '0 : mag_sum_r) + SUM_W'(mag);
    sq_sum_nxt  = (new_set ? '0 : sq_sum_r) + SQ_W'(mag_sq);
    count       = (new_set ? '0 : {1'b0, seen_r}) + 1'b1;
    limit       = (len_r == '0) ? LEN_W'(1) : len_r;
  end

  assign stat.trace_end = (count >= {1'b0, limit});

  // Hold config, accumulate samples, snapshot at trace end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_RESET;
      sum_r     <= '0;
      mag_sum_r <= '0;
      sq_sum_r  <= '0;
      seen_r    <= '0;
    end else begin
      if (cfg_we) len_r <= cfg_wdata;
      if (cmd.accept) begin
        if (stat.trace_end) begin
          sum_r     <= '0;
          mag_sum_r <= '0;
          sq_sum_r  <= '0;
          seen_r    <= '0;
        end else begin
          sum_r     <= sum_nxt;
          mag_sum_r <= mag_sum_nxt;
          sq_sum_r  <= sq_sum_nxt;
          seen_r    <= count[LEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.trace_end) begin
      snap_sum_r <= sum_nxt;
      snap_mag_r <= mag_sum_nxt;
      snap_sq_r  <= sq_sum_nxt;
      n_r        <= count[LEN_W-1:0];
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [DVD_W-1:0] dvd_r;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [LEN_W:0]   trial;
  logic             ge;
  logic             neg;
  logic [SUM_W-1:0] smag;
  logic [Q_W-1:0]   mean_sat;
  logic [Q_W-1:0]   mean_q;
  logic signed [31:0] mean_r;
  logic [30:0]      abs_r;
  logic             rms_ovf_r;

  always_comb begin
    neg     = snap_sum_r[SUM_W-1];
    smag    = neg ? SUM_W'(-snap_sum_r) : SUM_W'(snap_sum_r);
    trial   = {rem_r, dvd_r[DVD_W-1]};
    ge      = (trial >= {1'b0, n_r});
    rem_nxt = ge ? LEN_W'(trial - {1'b0, n_r}) : trial[LEN_W-1:0];
    quo_nxt = {quo_r[Q_W-2:0], ge};
    ovf_nxt = ovf_r | quo_r[Q_W-1];
    mean_sat = neg ? SAT_NEG : SAT_POS;
    mean_q   = (ovf_nxt || quo_nxt > mean_sat) ? mean_sat : quo_nxt;
  end

  assign stat.div_last = (cnt_r == CNT_LAST);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
      case (cmd.sel)
        SEL_MEAN: dvd_r <= DVD_W'(smag) << FRAC_BITS;
        SEL_ABS:  dvd_r <= DVD_W'(snap_mag_r) << FRAC_BITS;
        default:  dvd_r <= DVD_W'(snap_sq_r) << (2 * FRAC_BITS);
      endcase
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      ovf_r <= ovf_nxt;
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r + 1'b1;
      if (stat.div_last) begin
        case (cmd.sel)
          SEL_MEAN: mean_r <= neg ? 32'(-mean_q) : 32'(mean_q);
          SEL_ABS:  abs_r  <= (ovf_nxt || quo_nxt > SAT_POS) ? U31_MAX : quo_nxt[30:0];
          default:  rms_ovf_r <= ovf_nxt;
        endcase
      end
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle
  logic [Q_W-1:0] rx_r, rres_r, rbit_r, rtry;
  logic [30:0]    rms_v;

  assign rtry           = rres_r + rbit_r;
  assign stat.root_last = rbit_r[0];

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rx_r   <= quo_r;
      rres_r <= '0;
      rbit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.root_step) begin
      if (rx_r >= rtry) begin
        rx_r   <= rx_r - rtry;
        rres_r <= (rres_r >> 1) + rbit_r;
      end else begin
        rres_r <= rres_r >> 1;
      end
      rbit_r <= rbit_r >> 2;
    end
  end

  assign rms_v = (rms_ovf_r || rres_r > SAT_POS) ? U31_MAX : rres_r[30:0];

  // Update ranges and load result register
  logic signed [31:0] lo_mean_r, hi_mean_r, lo_mean_nxt, hi_mean_nxt;
  logic [30:0] lo_abs_r, hi_abs_r, lo_rms_r, hi_rms_r;
  logic [30:0] lo_abs_nxt, hi_abs_nxt, lo_rms_nxt, hi_rms_nxt;
  logic        out_valid_r;

  always_comb begin
    lo_mean_nxt = (mean_r < lo_mean_r) ? mean_r : lo_mean_r;
    hi_mean_nxt = (mean_r > hi_mean_r) ? mean_r : hi_mean_r;
    lo_abs_nxt  = (abs_r < lo_abs_r) ? abs_r : lo_abs_r;
    hi_abs_nxt  = (abs_r > hi_abs_r) ? abs_r : hi_abs_r;
    lo_rms_nxt  = (rms_v < lo_rms_r) ? rms_v : lo_rms_r;
    hi_rms_nxt  = (rms_v > hi_rms_r) ? rms_v : hi_rms_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_mean_r   <= S32_MAX;
      hi_mean_r   <= S32_MIN;
      lo_abs_r    <= U31_MAX;
      hi_abs_r    <= '0;
      lo_rms_r    <= U31_MAX;
      hi_rms_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && new_set) begin
        lo_mean_r <= S32_MAX;
        hi_mean_r <= S32_MIN;
        lo_abs_r  <= U31_MAX;
        hi_abs_r  <= '0;
        lo_rms_r  <= U31_MAX;
        hi_rms_r  <= '0;
      end else if (cmd.out_load) begin
        lo_mean_r <= lo_mean_nxt;
        hi_mean_r <= hi_mean_nxt;
        lo_abs_r  <= lo_abs_nxt;
        hi_abs_r  <= hi_abs_nxt;
        lo_rms_r  <= lo_rms_nxt;
        hi_rms_r  <= hi_rms_nxt;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      trace_mean       <= mean_r;
      trace_abs_mean   <= abs_r;
      trace_rms        <= rms_v;
      min_of_means     <= lo_mean_nxt;
      max_of_means     <= hi_mean_nxt;
      min_of_abs_means <= lo_abs_nxt;
      max_of_abs_means <= hi_abs_nxt;
      min_of_rms       <= lo_rms_nxt;
      max_of_rms       <= hi_rms_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_full = out_valid_r && !out_ready;

endmodule

[design/trace_amplitude_statistics.sv]
// Top level: per-trace mean, absolute mean and RMS with running ranges.
// A sample that does not end a trace leaves the controller idle; the next is taken the cycle after.
// A trace-ending sample runs three divides (mean, absolute mean, mean square), each a load and
// then one step per dividend bit, then a root load and its steps, and one result load, which
// waits while an earlier result is held; no new sample is taken until that load.
// Reset (rst_n low, synchronous) clears sums, count and ranges; trace length is 1000.
module trace_amplitude_statistics #(
  parameter int SAMPLE_BITS = tas_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = tas_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tas_in_if.sink                    in_ch,
  tas_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [tas_pkg::LEN_W-1:0] cfg_wdata
);
  import tas_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tas_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .sample           (in_ch.sample),
    .new_set          (in_ch.new_set),
    .out_ready        (out_ch.ready),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .trace_mean       (out_ch.trace_mean),
    .trace_abs_mean   (out_ch.trace_abs_mean),
    .trace_rms        (out_ch.trace_rms),
    .min_of_means     (out_ch.min_of_means),
    .max_of_means     (out_ch.max_of_means),
    .min_of_abs_means (out_ch.min_of_abs_means),
    .max_of_abs_means (out_ch.max_of_abs_means),
    .min_of_rms       (out_ch.min_of_rms),
    .max_of_rms       (out_ch.max_of_rms)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for the trace amplitude statistics block.
`timescale 1ns / 1ps

module testbench;
  import tas_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 700;
  localparam logic [63:0] POS_LIMIT = 64'd2147483647;
  localparam logic [63:0] NEG_LIMIT_MAG = 64'd2147483648;

  typedef struct {
    logic signed [31:0] mean;
    logic [30:0] abs_mean;
    logic [30:0] rms;
    logic signed [31:0] mean_lo;
    logic signed [31:0] mean_hi;
    logic [30:0] abs_lo;
    logic [30:0] abs_hi;
    logic [30:0] rms_lo;
    logic [30:0] rms_hi;
  } trace_stats_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  tas_in_if #(.SAMPLE_BITS(SW)) in_ch ();
  tas_out_if out_ch ();

  trace_amplitude_statistics #(.SAMPLE_BITS(SW), .FRAC_BITS(FW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [LEN_W-1:0] trace_len;
  logic [63:0] sum_signed, sum_mag, sum_sq;
  int unsigned count_seen;
  longint mean_lo, mean_hi, abs_lo, abs_hi, rms_lo, rms_hi;

  trace_stats_t pending_stats[$];
  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_on;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Floor of m * 2^sh / n, limited to sat
  function automatic logic [63:0] scaled_quotient(logic [63:0] m, logic [63:0] n,
                                                  int sh, logic [63:0] sat);
    logic [63:0] q, r, v;
    q = m / n;
    r = m % n;
    if (q > (sat >> sh)) return sat;
    v = (q << sh) + ((r << sh) / n);
    return (v > sat) ? sat : v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void clear_ranges();
    mean_lo = POS_LIMIT;
    mean_hi = -longint'(NEG_LIMIT_MAG);
    abs_lo = POS_LIMIT;
    abs_hi = 0;
    rms_lo = POS_LIMIT;
    rms_hi = 0;
  endfunction

  function automatic void clear_sums();
    sum_signed = 0;
    sum_mag = 0;
    sum_sq = 0;
    count_seen = 0;
  endfunction

  // Advance the predictor by one accepted sample; queue a result at trace end
  function automatic void trace_stats_predict(logic signed [SW-1:0] smp, logic ns);
    longint v;
    logic [63:0] mag, n, limit, mres, ares, rres, quo, t;
    longint mean_v;
    int unsigned cnt;
    trace_stats_t r;
    v = smp;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    if (ns) begin
      clear_ranges();
      clear_sums();
    end
    sum_signed = sum_signed + 64'(v);
    sum_mag = sum_mag + mag;
    sum_sq = sum_sq + mag * mag;
    cnt = count_seen + 1;
    limit = (trace_len == 0) ? 64'd1 : 64'(trace_len);
    if (64'(cnt) < limit) begin
      count_seen = cnt;
      return;
    end
    n = 64'(cnt);
    if (sum_signed[63]) begin
      mres = scaled_quotient(-sum_signed, n, FW, NEG_LIMIT_MAG);
      mean_v = -longint'(mres);
    end else begin
      mres = scaled_quotient(sum_signed, n, FW, POS_LIMIT);
      mean_v = longint'(mres);
    end
    ares = scaled_quotient(sum_mag, n, FW, POS_LIMIT);
    quo = sum_sq / n;
    if (quo > ({64{1'b1}} >> (2 * FW))) begin
      rres = POS_LIMIT;
    end else begin
      t = (quo << (2 * FW)) + (((sum_sq % n) << (2 * FW)) / n);
      rres = floor_sqrt(t);
      if (rres > POS_LIMIT) rres = POS_LIMIT;
    end
    clear_sums();
    if (mean_v < mean_lo) mean_lo = mean_v;
    if (mean_v > mean_hi) mean_hi = mean_v;
    if (longint'(ares) < abs_lo) abs_lo = ares;
    if (longint'(ares) > abs_hi) abs_hi = ares;
    if (longint'(rres) < rms_lo) rms_lo = rres;
    if (longint'(rres) > rms_hi) rms_hi = rres;
    r.mean = mean_v[31:0];
    r.abs_mean = ares[30:0];
    r.rms = rres[30:0];
    r.mean_lo = mean_lo[31:0];
    r.mean_hi = mean_hi[31:0];
    r.abs_lo = abs_lo[30:0];
    r.abs_hi = abs_hi[30:0];
    r.rms_lo = rms_lo[30:0];
    r.rms_hi = rms_hi[30:0];
    pending_stats.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Receiver: check each taken result, then pick ready for the next edge
  always @(posedge clk) begin
    trace_stats_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result with none pending", out_ch.trace_mean, 32'h0);
      end else begin
        w = pending_stats.pop_front();
        check_field("trace_mean", out_ch.trace_mean, w.mean);
        check_field("trace_abs_mean", {1'b0, out_ch.trace_abs_mean}, {1'b0, w.abs_mean});
        check_field("trace_rms", {1'b0, out_ch.trace_rms}, {1'b0, w.rms});
        check_field("min_of_means", out_ch.min_of_means, w.mean_lo);
        check_field("max_of_means", out_ch.max_of_means, w.mean_hi);
        check_field("min_of_abs_means", {1'b0, out_ch.min_of_abs_means}, {1'b0, w.abs_lo});
        check_field("max_of_abs_means", {1'b0, out_ch.max_of_abs_means}, {1'b0, w.abs_hi});
        check_field("min_of_rms", {1'b0, out_ch.min_of_rms}, {1'b0, w.rms_lo});
        check_field("max_of_rms", {1'b0, out_ch.max_of_rms}, {1'b0, w.rms_hi});
      end
    end
    if (hold_on) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item and hold it until taken
  task automatic send_sample(logic signed [SW-1:0] smp, logic ns);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.new_set <= ns;
    do @(posedge clk); while (!in_ch.ready);
    trace_stats_predict(smp, ns);
  endtask

  // Drop valid, drain pending results and let the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] len);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    trace_len = len;
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {1'b1, {(SW-1){1'b0}}};
      1: return {1'b0, {(SW-1){1'b1}}};
      2, 3: return SW'($signed($urandom_range(64)) - 32);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    write_length(1);
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh000000, 1'b0);
    send_sample(24'shFFFFFF, 1'b0);
    send_sample(24'sh000001, 1'b1);
    // saturate all three at full negative scale
    write_length(2);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh000003, 1'b0);
    send_sample(24'sh555555, 1'b1);
    send_sample(24'shAAAAAA, 1'b0);
    // zero length behaves as one
    write_length(0);
    send_sample(24'sh001234, 1'b0);
    send_sample(24'shFEDCBA, 1'b1);
    // longest length, partial trace, then shrink mid-trace
    write_length(16'hFFFF);
    send_sample(24'sh000100, 1'b0);
    send_sample(24'shFFFF00, 1'b0);
    send_sample(24'sh123456, 1'b0);
    write_length(2);
    send_sample(24'sh000007, 1'b0);
    send_sample(24'sh000005, 1'b0);
    // new set drops the partial trace
    send_sample(24'sh400000, 1'b1);
    send_sample(24'sh000010, 1'b1);
    send_sample(24'shFFFFF0, 1'b0);
  endtask

  task automatic test_reset_length();
    write_length(1000);
    for (int i = 0; i < 1000; i++) send_sample(pick_sample(), i == 0);
  endtask

  // Data sets of whole traces, with some broken sets and odd lengths
  task automatic test_random_sets(int idle_pct, int stall_pct, int n_items);
    int sent, len, traces, total;
    logic ns;
    sent = 0;
    while (sent < n_items) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      case ($urandom_range(19))
        0: len = 0;
        1: len = $urandom_range(20, 40);
        default: len = $urandom_range(1, 8);
      endcase
      write_length(LEN_W'(len));
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      traces = $urandom_range(2, 8);
      total = ((len == 0) ? 1 : len) * traces;
      for (int i = 0; i < total; i++) begin
        ns = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
        send_sample(pick_sample(), ns);
      end
      sent += total;
    end
  endtask

  // Hold the receiver off while samples keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_length(1);
    @(posedge clk);
    fork
      begin
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) send_sample(pick_sample(), i == 0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.new_set = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_on = 1'b0;
    trace_len = LEN_RESET;
    clear_sums();
    clear_ranges();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_reset_length();
    test_random_sets(0, 0, 20);
    test_random_sets(60, 0, 20);
    test_random_sets(0, 60, 20);
    test_random_sets(18, 18, 20);
    test_backpressure();

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
